// ----- hdl/lz4_frame_decompressor_unit_defines.svh -----
// Assertion macros used by the decompressor top level.
`ifndef LZ4_FRAME_DECOMPRESSOR_UNIT_DEFINES_SVH
`define LZ4_FRAME_DECOMPRESSOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LFD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define LFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/lfd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZ4 frame decompressor package
// Phase codes, result codes, constants, the per-item control record and a saturating add.
// ----------------------------------------------------------------------------
package lfd_pkg;

    localparam int unsigned HISTORY_DEPTH_DEF = 65536;
    localparam logic [31:0] FRAME_MAGIC       = 32'h184D_2204;
    localparam logic [3:0]  NIBBLE_EXT        = 4'hF;
    localparam logic [7:0]  BYTE_EXT          = 8'hFF;

    typedef enum logic [4:0] {
        PH_MAGIC     = 5'd0,
        PH_FLAG      = 5'd1,
        PH_BD        = 5'd2,
        PH_CSIZE     = 5'd3,
        PH_DICT      = 5'd4,
        PH_HCHK      = 5'd5,
        PH_BSIZE     = 5'd6,
        PH_RAW       = 5'd7,
        PH_TOKEN     = 5'd8,
        PH_LITEXT    = 5'd9,
        PH_LITERAL   = 5'd10,
        PH_OFFSET    = 5'd11,
        PH_MATCHEXT  = 5'd12,
        PH_COPY      = 5'd13,
        PH_BCHK      = 5'd14,
        PH_CCHK      = 5'd15,
        PH_ERR_MAGIC = 5'd16,
        PH_ERR_DIST  = 5'd17,
        PH_ERR_OVR   = 5'd18
    } t_phase;

    typedef enum logic [1:0] {
        KIND_LITERAL = 2'd0,
        KIND_MATCH   = 2'd1,
        KIND_RAW     = 2'd2,
        KIND_STATUS  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_FRAME_DONE = 3'd1,
        ST_BAD_MAGIC  = 3'd2,
        ST_BAD_DIST   = 3'd3,
        ST_MISPLACED  = 3'd4,
        ST_OVERRUN    = 3'd5
    } t_status;

    // Per-transaction record handed from the parser to the second stage
    typedef struct packed {
        logic       res;
        t_kind      kind;
        logic       last;
        t_status    status;
        logic       we;
        logic [7:0] data;
    } t_lfd_op;

    // Saturating 32-bit add
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

// ----- hdl/lfd_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decompressor input channel
// Valid/ready channel carrying one command and one frame byte.
// ----------------------------------------------------------------------------
interface lfd_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] in_byte;

    modport source (output valid, output command, output in_byte, input ready);
    modport sink   (input valid, input command, input in_byte, output ready);
endinterface

// ----------------------------------------------------------------------------
// Decompressor output channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface lfd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] out_kind;
    logic       last_in_block;
    logic [2:0] status;

    modport source (output valid, output out_byte, output out_kind, output last_in_block,
                    output status, input ready);
    modport sink   (input valid, input out_byte, input out_kind, input last_in_block,
                    input status, output ready);
endinterface

// ----- hdl/lfd_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered on read enable.
// ----------------------------------------------------------------------------
module lfd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = lfd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hdl/lfd_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZ4 frame parser
// Holds the frame/block control state, decodes each transaction and issues
// the history read and write addresses for it.
// ----------------------------------------------------------------------------
module lfd_parser #(
    parameter int unsigned HISTORY_DEPTH = lfd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic                             i_command,
    input  logic [7:0]                       i_in_byte,
    output lfd_pkg::t_lfd_op                 o_op,
    output logic [$clog2(HISTORY_DEPTH)-1:0] o_raddr,
    output logic [$clog2(HISTORY_DEPTH)-1:0] o_waddr
);
    localparam int unsigned AW = $clog2(HISTORY_DEPTH);
    localparam logic [AW:0] DEPTH_W = (AW+1)'(HISTORY_DEPTH);

    lfd_pkg::t_phase r_phase, n_phase;
    logic [3:0]  r_fbc, n_fbc;
    logic [31:0] r_acc, n_acc;
    logic [7:0]  r_flags, n_flags;
    logic [31:0] r_blk, n_blk;
    logic [31:0] r_lit, n_lit;
    logic [3:0]  r_mnl, n_mnl;
    logic [15:0] r_dist, n_dist;
    logic [31:0] r_copy, n_copy;
    logic [AW-1:0] r_wp, n_wp;
    logic [AW:0]   r_prod, n_prod;

    // Decode of one transaction
    always_comb begin
        logic [3:0]  v_fbc;
        logic [31:0] v_acc;
        logic [AW:0] v_dist;
        logic [AW:0] v_wp;
        n_phase = r_phase; n_fbc = r_fbc; n_acc = r_acc; n_flags = r_flags;
        n_blk = r_blk; n_lit = r_lit; n_mnl = r_mnl; n_dist = r_dist;
        n_copy = r_copy; n_wp = r_wp; n_prod = r_prod;
        o_op = '{res: 1'b0, kind: lfd_pkg::KIND_STATUS, last: 1'b0,
                 status: lfd_pkg::ST_OK, we: 1'b0, data: i_in_byte};
        o_waddr = r_wp;
        v_wp = {1'b0, r_wp};
        v_dist = (AW+1)'({1'b0, r_dist});
        o_raddr = (v_wp >= v_dist) ? AW'(v_wp - v_dist) : AW'(v_wp + DEPTH_W - v_dist);
        // field gather
        v_fbc = r_fbc + 4'd1;
        v_acc = r_acc;
        if (r_fbc < 4'd4) begin
            v_acc = r_acc | ({24'd0, i_in_byte} << {r_fbc[1:0], 3'b000});
        end

        priority if (r_phase == lfd_pkg::PH_ERR_MAGIC) begin
            o_op.res = 1'b1; o_op.status = lfd_pkg::ST_BAD_MAGIC;
        end else if (r_phase == lfd_pkg::PH_ERR_DIST) begin
            o_op.res = 1'b1; o_op.status = lfd_pkg::ST_BAD_DIST;
        end else if (r_phase == lfd_pkg::PH_ERR_OVR) begin
            o_op.res = 1'b1; o_op.status = lfd_pkg::ST_OVERRUN;
        end else if (i_command) begin
            // drain one match byte
            o_op.res = 1'b1;
            if (r_phase != lfd_pkg::PH_COPY) begin
                o_op.status = lfd_pkg::ST_MISPLACED;
            end else begin
                o_op.kind = lfd_pkg::KIND_MATCH;
                o_op.we = 1'b1;
                n_wp = (v_wp + 1'b1 >= DEPTH_W) ? '0 : r_wp + 1'b1;
                n_prod = (r_prod < DEPTH_W) ? r_prod + 1'b1 : r_prod;
                n_copy = r_copy - 32'd1;
                if (r_copy == 32'd1) begin
                    if (r_blk == 32'd0) begin
                        n_phase = r_flags[4] ? lfd_pkg::PH_BCHK : lfd_pkg::PH_BSIZE;
                        n_fbc = '0; n_acc = '0;
                        o_op.last = 1'b1;
                    end else begin
                        n_phase = lfd_pkg::PH_TOKEN;
                    end
                end
            end
        end else begin
            unique case (r_phase)
                lfd_pkg::PH_MAGIC: begin
                    n_fbc = v_fbc; n_acc = v_acc;
                    if (v_fbc == 4'd4) begin
                        if (v_acc == lfd_pkg::FRAME_MAGIC) begin
                            n_phase = lfd_pkg::PH_FLAG;
                        end else begin
                            n_phase = lfd_pkg::PH_ERR_MAGIC;
                            o_op.res = 1'b1; o_op.status = lfd_pkg::ST_BAD_MAGIC;
                        end
                    end
                end
                lfd_pkg::PH_FLAG: begin
                    n_flags = i_in_byte;
                    n_phase = lfd_pkg::PH_BD;
                end
                lfd_pkg::PH_BD: begin
                    n_fbc = '0; n_acc = '0;
                    n_phase = r_flags[3] ? lfd_pkg::PH_CSIZE :
                              r_flags[0] ? lfd_pkg::PH_DICT : lfd_pkg::PH_HCHK;
                end
                lfd_pkg::PH_CSIZE: begin
                    n_fbc = v_fbc;
                    if (v_fbc == 4'd8) begin
                        n_fbc = '0; n_acc = '0;
                        n_phase = r_flags[0] ? lfd_pkg::PH_DICT : lfd_pkg::PH_HCHK;
                    end
                end
                lfd_pkg::PH_DICT: begin
                    n_fbc = v_fbc;
                    if (v_fbc == 4'd4) begin
                        n_fbc = '0; n_acc = '0; n_phase = lfd_pkg::PH_HCHK;
                    end
                end
                lfd_pkg::PH_HCHK: begin
                    n_fbc = '0; n_acc = '0; n_phase = lfd_pkg::PH_BSIZE;
                end
                lfd_pkg::PH_BSIZE: begin
                    n_fbc = v_fbc; n_acc = v_acc;
                    if (v_fbc >= 4'd4) begin
                        if (v_acc == 32'd0) begin
                            if (r_flags[2]) begin
                                n_fbc = '0; n_acc = '0; n_phase = lfd_pkg::PH_CCHK;
                            end else begin
                                // end mark: back to a fresh frame
                                n_phase = lfd_pkg::PH_MAGIC; n_fbc = '0; n_acc = '0;
                                n_flags = '0; n_blk = '0; n_lit = '0; n_mnl = '0;
                                n_dist = '0; n_copy = '0; n_wp = '0; n_prod = '0;
                                o_op.res = 1'b1; o_op.status = lfd_pkg::ST_FRAME_DONE;
                            end
                        end else begin
                            n_wp = '0; n_prod = '0;
                            if (v_acc[31]) begin
                                n_blk = {1'b0, v_acc[30:0]};
                                if (v_acc[30:0] == 31'd0) begin
                                    n_fbc = '0; n_acc = '0;
                                    n_phase = r_flags[4] ? lfd_pkg::PH_BCHK
                                                         : lfd_pkg::PH_BSIZE;
                                end else begin
                                    n_phase = lfd_pkg::PH_RAW;
                                end
                            end else begin
                                n_blk = v_acc;
                                n_phase = lfd_pkg::PH_TOKEN;
                            end
                        end
                    end
                end
                lfd_pkg::PH_RAW, lfd_pkg::PH_LITERAL: begin
                    n_blk = r_blk - 32'd1;
                    o_op.res = 1'b1; o_op.we = 1'b1;
                    o_op.kind = (r_phase == lfd_pkg::PH_RAW) ? lfd_pkg::KIND_RAW
                                                              : lfd_pkg::KIND_LITERAL;
                    n_wp = (v_wp + 1'b1 >= DEPTH_W) ? '0 : r_wp + 1'b1;
                    n_prod = (r_prod < DEPTH_W) ? r_prod + 1'b1 : r_prod;
                    if (r_phase == lfd_pkg::PH_LITERAL) begin
                        n_lit = r_lit - 32'd1;
                    end
                    if (r_phase == lfd_pkg::PH_RAW || n_lit == 32'd0) begin
                        if (n_blk == 32'd0) begin
                            n_fbc = '0; n_acc = '0; o_op.last = 1'b1;
                            n_phase = r_flags[4] ? lfd_pkg::PH_BCHK : lfd_pkg::PH_BSIZE;
                        end else if (r_phase == lfd_pkg::PH_LITERAL) begin
                            n_fbc = '0; n_acc = '0; n_phase = lfd_pkg::PH_OFFSET;
                        end
                    end
                end
                lfd_pkg::PH_TOKEN, lfd_pkg::PH_LITEXT: begin
                    n_blk = r_blk - 32'd1;
                    if (r_phase == lfd_pkg::PH_TOKEN) begin
                        n_lit = {28'd0, i_in_byte[7:4]};
                        n_mnl = i_in_byte[3:0];
                    end else begin
                        n_lit = lfd_pkg::sat_add(r_lit, {24'd0, i_in_byte});
                    end
                    if ((r_phase == lfd_pkg::PH_TOKEN && i_in_byte[7:4] == lfd_pkg::NIBBLE_EXT)
                        || (r_phase == lfd_pkg::PH_LITEXT
                            && i_in_byte == lfd_pkg::BYTE_EXT)) begin
                        // more length bytes follow
                        if (n_blk == 32'd0) begin
                            n_phase = lfd_pkg::PH_ERR_OVR;
                            o_op.res = 1'b1; o_op.status = lfd_pkg::ST_OVERRUN;
                        end else begin
                            n_phase = lfd_pkg::PH_LITEXT;
                        end
                    end else if (n_lit > n_blk) begin
                        n_phase = lfd_pkg::PH_ERR_OVR;
                        o_op.res = 1'b1; o_op.status = lfd_pkg::ST_OVERRUN;
                    end else if (n_lit == 32'd0) begin
                        n_fbc = '0; n_acc = '0;
                        if (n_blk == 32'd0) begin
                            n_phase = r_flags[4] ? lfd_pkg::PH_BCHK : lfd_pkg::PH_BSIZE;
                        end else begin
                            n_phase = lfd_pkg::PH_OFFSET;
                        end
                    end else begin
                        n_phase = lfd_pkg::PH_LITERAL;
                    end
                end
                lfd_pkg::PH_OFFSET, lfd_pkg::PH_MATCHEXT: begin
                    n_blk = r_blk - 32'd1;
                    if (r_phase == lfd_pkg::PH_OFFSET) begin
                        n_fbc = v_fbc; n_acc = v_acc;
                    end
                    if (r_phase == lfd_pkg::PH_OFFSET && v_fbc < 4'd2) begin
                        if (n_blk == 32'd0) begin
                            n_phase = lfd_pkg::PH_ERR_OVR;
                            o_op.res = 1'b1; o_op.status = lfd_pkg::ST_OVERRUN;
                        end
                    end else if ((r_phase == lfd_pkg::PH_OFFSET
                                  && r_mnl == lfd_pkg::NIBBLE_EXT)
                                 || (r_phase == lfd_pkg::PH_MATCHEXT
                                     && i_in_byte == lfd_pkg::BYTE_EXT)) begin
                        // extended match length continues
                        if (r_phase == lfd_pkg::PH_OFFSET) begin
                            n_dist = v_acc[15:0];
                            n_copy = {28'd0, r_mnl};
                        end else begin
                            n_copy = lfd_pkg::sat_add(r_copy, {24'd0, i_in_byte});
                        end
                        if (n_blk == 32'd0) begin
                            n_phase = lfd_pkg::PH_ERR_OVR;
                            o_op.res = 1'b1; o_op.status = lfd_pkg::ST_OVERRUN;
                        end else begin
                            n_phase = lfd_pkg::PH_MATCHEXT;
                        end
                    end else begin
                        if (r_phase == lfd_pkg::PH_OFFSET) begin
                            n_dist = v_acc[15:0];
                            n_copy = {28'd0, r_mnl} + 32'd4;
                        end else begin
                            n_copy = lfd_pkg::sat_add(
                                lfd_pkg::sat_add(r_copy, {24'd0, i_in_byte}), 32'd4);
                        end
                        if (n_dist == 16'd0 || {1'b0, n_dist} > 17'(r_prod)) begin
                            n_phase = lfd_pkg::PH_ERR_DIST;
                            o_op.res = 1'b1; o_op.status = lfd_pkg::ST_BAD_DIST;
                        end else begin
                            n_phase = lfd_pkg::PH_COPY;
                        end
                    end
                end
                lfd_pkg::PH_COPY: begin
                    o_op.res = 1'b1; o_op.status = lfd_pkg::ST_MISPLACED;
                end
                lfd_pkg::PH_BCHK: begin
                    n_fbc = v_fbc;
                    if (v_fbc == 4'd4) begin
                        n_fbc = '0; n_acc = '0; n_phase = lfd_pkg::PH_BSIZE;
                    end
                end
                lfd_pkg::PH_CCHK: begin
                    n_fbc = v_fbc;
                    if (v_fbc == 4'd4) begin
                        n_phase = lfd_pkg::PH_MAGIC; n_fbc = '0; n_acc = '0;
                        n_flags = '0; n_blk = '0; n_lit = '0; n_mnl = '0;
                        n_dist = '0; n_copy = '0; n_wp = '0; n_prod = '0;
                        o_op.res = 1'b1; o_op.status = lfd_pkg::ST_FRAME_DONE;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
        if (o_op.kind == lfd_pkg::KIND_STATUS) begin
            o_op.data = 8'd0;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= lfd_pkg::PH_MAGIC;
            r_fbc <= '0; r_acc <= '0; r_flags <= '0; r_blk <= '0; r_lit <= '0;
            r_mnl <= '0; r_dist <= '0; r_copy <= '0; r_wp <= '0; r_prod <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_fbc <= n_fbc; r_acc <= n_acc; r_flags <= n_flags; r_blk <= n_blk;
            r_lit <= n_lit; r_mnl <= n_mnl; r_dist <= n_dist; r_copy <= n_copy;
            r_wp <= n_wp; r_prod <= n_prod;
        end
    end
endmodule

// ----- hdl/lz4_frame_decompressor_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZ4 frame decompressor
// Byte-serial LZ4 frame decoder with a per-block history RAM.
// ----------------------------------------------------------------------------
// Takes one transaction per clock, save for the stall below: a frame byte or a
// drain of one match byte. Each transaction is decoded in the parser cycle,
// which also issues the history RAM read. The accepting edge loads the second
// stage; during the next cycle that stage picks up the read data (or the byte
// being written, for a copy at distance one) and writes it back when it
// advances, at the edge that also loads the output register. The history RAM's
// read/write pair per byte sets the rate of one transaction per cycle. While a
// result waits unread, one more transaction is taken into the second stage, and
// then the input stalls until the output register frees. The history needs no
// clearing after reset.
`include "lz4_frame_decompressor_unit_defines.svh"
module lz4_frame_decompressor_unit #(
    parameter int unsigned HISTORY_DEPTH = lfd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lfd_in_if.sink     i_in,
    lfd_out_if.source  o_out
);
    localparam int unsigned AW = $clog2(HISTORY_DEPTH);

    lfd_pkg::t_lfd_op w_op, r_s1_op;
    logic [AW-1:0] w_raddr, w_waddr, r_s1_waddr;
    logic          r_s1_valid, r_out_valid, r_fwd_hit;
    logic [7:0]    r_fwd_data, w_rdata, w_s1_byte;
    logic          w_accept, w_out_free, w_s1_adv, w_we;
    logic [7:0]    r_out_byte;
    logic [1:0]    r_out_kind;
    logic          r_out_last;
    logic [2:0]    r_out_status;

    // Handshake
    assign w_out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_s1_valid || w_out_free;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_s1_adv   = r_s1_valid && w_out_free;

    lfd_parser #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_command (i_in.command),
        .i_in_byte (i_in.in_byte),
        .o_op      (w_op),
        .o_raddr   (w_raddr),
        .o_waddr   (w_waddr)
    );

    // Second stage byte: match bytes from history, forwarded on a back-to-back hit
    assign w_s1_byte = (r_s1_op.kind == lfd_pkg::KIND_MATCH)
                     ? (r_fwd_hit ? r_fwd_data : w_rdata) : r_s1_op.data;
    assign w_we = w_s1_adv && r_s1_op.we;

    lfd_ram #(.WIDTH(8), .DEPTH(HISTORY_DEPTH)) u_history (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_s1_waddr),
        .i_wdata (w_s1_byte),
        .i_re    (w_accept),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Second stage register and forwarding capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= w_accept;
            if (w_accept) begin
                r_fwd_hit <= w_we && (r_s1_waddr == w_raddr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_op    <= w_op;
            r_s1_waddr <= w_waddr;
            r_fwd_data <= w_s1_byte;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_s1_valid && r_s1_op.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out_byte   <= w_s1_byte;
            r_out_kind   <= r_s1_op.kind;
            r_out_last   <= r_s1_op.last;
            r_out_status <= r_s1_op.status;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.out_byte      = r_out_byte;
    assign o_out.out_kind      = r_out_kind;
    assign o_out.last_in_block = r_out_last;
    assign o_out.status        = r_out_status;

    // Checks
    `LFD_ASSERT_NOW(a_stall_only_when_full, i_clk, i_rst_n, !i_in.ready,
        r_s1_valid && r_out_valid && !o_out.ready, "input stalled without a full pipe")
    `LFD_ASSERT_NOW(a_write_only_on_advance, i_clk, i_rst_n, w_we,
        r_s1_valid && w_out_free, "history written by a held stage")
    `LFD_ASSERT_NEXT(a_fwd_from_write, i_clk, i_rst_n, w_accept && !w_we,
        !r_fwd_hit, "forward hit without a write")
endmodule

// ----- tb/tb_lz4_frame_decompressor_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZ4 frame decompressor testbench
// Builds LZ4 frames with raw and compressed blocks, including literals, matches
// and overlapping copies, and interleaves the matching drain commands. Stray
// commands are mixed in as noise, and the run ends on one error condition,
// chosen at random, that locks up the decoder. A cycle-free decoder model
// predicts every result, and each received result is checked field by field.
// Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module tb_lz4_frame_decompressor_unit;

    localparam int TAIL_ITEMS  = 200;
    localparam int ITEM_TARGET = 1950;

    typedef struct {
        logic       cmd;
        logic [7:0] data;
    } t_cmd_item;

    typedef struct {
        logic             data_b;
        logic [7:0]       data;
        lfd_pkg::t_kind   kind;
        logic             last;
        lfd_pkg::t_status status;
    } t_out_item;

    logic i_clk;
    logic i_rst_n;

    lfd_in_if  in_ch();
    lfd_out_if out_ch();

    lz4_frame_decompressor_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Clock
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    t_cmd_item cmd_q[$];
    t_cmd_item blk_q[$];
    t_out_item decoded_q[$];
    int        fail_cnt = 0;

    // ------------------------------------------------------------------------
    // Decoder model state
    // ------------------------------------------------------------------------
    lfd_pkg::t_phase ph;
    int unsigned     fcnt;
    logic [31:0]     facc;
    logic [7:0]      flags;
    logic [31:0]     blk_rem;
    logic [31:0]     lit_rem;
    logic [31:0]     mnib;
    logic [15:0]     mdist;
    logic [31:0]     copy_rem;
    logic [7:0]      hist [65536];
    logic [15:0]     wptr;
    logic [16:0]     produced;

    function automatic logic [31:0] add_clamped(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    task automatic put_result(input logic [7:0] d, input lfd_pkg::t_kind k, input logic l,
                              input lfd_pkg::t_status s);
        t_out_item r;
        r.data_b = 1'b0;
        r.data = d;
        r.kind = k;
        r.last = l;
        r.status = s;
        decoded_q.insert(decoded_q.size(), r);
    endtask

    task automatic put_status(input lfd_pkg::t_status s);
        put_result(8'd0, lfd_pkg::KIND_STATUS, 1'b0, s);
    endtask

    task automatic start_field(input lfd_pkg::t_phase nxt);
        ph = nxt;
        fcnt = 0;
        facc = '0;
    endtask

    task automatic gather(input logic [7:0] b);
        if (fcnt < 4) facc = facc | (32'(b) << (8 * fcnt));
        fcnt++;
    endtask

    task automatic put_hist(input logic [7:0] b);
        hist[wptr] = b;
        wptr = wptr + 16'd1;
        if (produced < 17'd65536) produced++;
    endtask

    task automatic restart_frame();
        start_field(lfd_pkg::PH_MAGIC);
        flags = '0;
        blk_rem = '0;
        lit_rem = '0;
        mnib = '0;
        mdist = '0;
        copy_rem = '0;
        wptr = '0;
        produced = '0;
    endtask

    task automatic end_block();
        start_field(flags[4] ? lfd_pkg::PH_BCHK : lfd_pkg::PH_BSIZE);
    endtask

    task automatic overrun();
        ph = lfd_pkg::PH_ERR_OVR;
        put_status(lfd_pkg::ST_OVERRUN);
    endtask

    task automatic close_literals();
        if (lit_rem > blk_rem) overrun();
        else if (lit_rem == 0) begin
            if (blk_rem == 0) end_block();
            else start_field(lfd_pkg::PH_OFFSET);
        end else begin
            ph = lfd_pkg::PH_LITERAL;
        end
    endtask

    task automatic close_match();
        if (mdist == 0 || 17'(mdist) > produced) begin
            ph = lfd_pkg::PH_ERR_DIST;
            put_status(lfd_pkg::ST_BAD_DIST);
        end else begin
            ph = lfd_pkg::PH_COPY;
        end
    endtask

    // One accepted transaction through the decoder model
    task automatic decode_transaction(input logic cmd, input logic [7:0] b);
        logic [7:0] v;
        logic       last;
        last = 1'b0;
        if (ph == lfd_pkg::PH_ERR_MAGIC) put_status(lfd_pkg::ST_BAD_MAGIC);
        else if (ph == lfd_pkg::PH_ERR_DIST) put_status(lfd_pkg::ST_BAD_DIST);
        else if (ph == lfd_pkg::PH_ERR_OVR) put_status(lfd_pkg::ST_OVERRUN);
        else if (cmd) begin
            // drain one match byte
            if (ph != lfd_pkg::PH_COPY) begin
                put_status(lfd_pkg::ST_MISPLACED);
            end else begin
                v = hist[wptr - mdist];
                put_hist(v);
                copy_rem--;
                if (copy_rem == 0) begin
                    if (blk_rem == 0) begin
                        end_block();
                        last = 1'b1;
                    end else begin
                        ph = lfd_pkg::PH_TOKEN;
                    end
                end
                put_result(v, lfd_pkg::KIND_MATCH, last, lfd_pkg::ST_OK);
            end
        end else begin
            unique case (ph)
                lfd_pkg::PH_MAGIC: begin
                    gather(b);
                    if (fcnt == 4) begin
                        if (facc == lfd_pkg::FRAME_MAGIC) ph = lfd_pkg::PH_FLAG;
                        else begin
                            ph = lfd_pkg::PH_ERR_MAGIC;
                            put_status(lfd_pkg::ST_BAD_MAGIC);
                        end
                    end
                end
                lfd_pkg::PH_FLAG: begin
                    flags = b;
                    ph = lfd_pkg::PH_BD;
                end
                lfd_pkg::PH_BD: begin
                    start_field(flags[3] ? lfd_pkg::PH_CSIZE :
                                flags[0] ? lfd_pkg::PH_DICT : lfd_pkg::PH_HCHK);
                end
                lfd_pkg::PH_CSIZE: begin
                    fcnt++;
                    if (fcnt == 8) start_field(flags[0] ? lfd_pkg::PH_DICT : lfd_pkg::PH_HCHK);
                end
                lfd_pkg::PH_DICT: begin
                    fcnt++;
                    if (fcnt == 4) start_field(lfd_pkg::PH_HCHK);
                end
                lfd_pkg::PH_HCHK: start_field(lfd_pkg::PH_BSIZE);
                lfd_pkg::PH_BSIZE: begin
                    gather(b);
                    if (fcnt >= 4) begin
                        if (facc == 0) begin
                            if (flags[2]) start_field(lfd_pkg::PH_CCHK);
                            else begin
                                restart_frame();
                                put_status(lfd_pkg::ST_FRAME_DONE);
                            end
                        end else begin
                            wptr = '0;
                            produced = '0;
                            if (facc[31]) begin
                                blk_rem = {1'b0, facc[30:0]};
                                if (blk_rem == 0) end_block();
                                else ph = lfd_pkg::PH_RAW;
                            end else begin
                                blk_rem = facc;
                                ph = lfd_pkg::PH_TOKEN;
                            end
                        end
                    end
                end
                lfd_pkg::PH_RAW: begin
                    blk_rem--;
                    put_hist(b);
                    if (blk_rem == 0) begin
                        end_block();
                        last = 1'b1;
                    end
                    put_result(b, lfd_pkg::KIND_RAW, last, lfd_pkg::ST_OK);
                end
                lfd_pkg::PH_TOKEN: begin
                    blk_rem--;
                    lit_rem = 32'(b[7:4]);
                    mnib = 32'(b[3:0]);
                    if (b[7:4] == lfd_pkg::NIBBLE_EXT) begin
                        if (blk_rem == 0) overrun();
                        else ph = lfd_pkg::PH_LITEXT;
                    end else begin
                        close_literals();
                    end
                end
                lfd_pkg::PH_LITEXT: begin
                    blk_rem--;
                    lit_rem = add_clamped(lit_rem, 32'(b));
                    if (b != lfd_pkg::BYTE_EXT) close_literals();
                    else if (blk_rem == 0) overrun();
                end
                lfd_pkg::PH_LITERAL: begin
                    blk_rem--;
                    lit_rem--;
                    put_hist(b);
                    if (lit_rem == 0) begin
                        if (blk_rem == 0) begin
                            end_block();
                            last = 1'b1;
                        end else begin
                            start_field(lfd_pkg::PH_OFFSET);
                        end
                    end
                    put_result(b, lfd_pkg::KIND_LITERAL, last, lfd_pkg::ST_OK);
                end
                lfd_pkg::PH_OFFSET: begin
                    blk_rem--;
                    gather(b);
                    if (fcnt < 2) begin
                        if (blk_rem == 0) overrun();
                    end else begin
                        mdist = facc[15:0];
                        copy_rem = mnib;
                        if (mnib == 32'(lfd_pkg::NIBBLE_EXT)) begin
                            if (blk_rem == 0) overrun();
                            else ph = lfd_pkg::PH_MATCHEXT;
                        end else begin
                            copy_rem = copy_rem + 32'd4;
                            close_match();
                        end
                    end
                end
                lfd_pkg::PH_MATCHEXT: begin
                    blk_rem--;
                    copy_rem = add_clamped(copy_rem, 32'(b));
                    if (b != lfd_pkg::BYTE_EXT) begin
                        copy_rem = add_clamped(copy_rem, 32'd4);
                        close_match();
                    end else if (blk_rem == 0) begin
                        overrun();
                    end
                end
                lfd_pkg::PH_COPY: put_status(lfd_pkg::ST_MISPLACED);
                lfd_pkg::PH_BCHK: begin
                    fcnt++;
                    if (fcnt == 4) start_field(lfd_pkg::PH_BSIZE);
                end
                lfd_pkg::PH_CCHK: begin
                    fcnt++;
                    if (fcnt == 4) begin
                        restart_frame();
                        put_status(lfd_pkg::ST_FRAME_DONE);
                    end
                end
                default: ;
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------------
    task automatic add_feed(input logic [7:0] b);
        t_cmd_item it;
        it.cmd = 1'b0;
        it.data = b;
        cmd_q.insert(cmd_q.size(), it);
    endtask

    task automatic add_drain(ref t_cmd_item q[$]);
        t_cmd_item it;
        it.cmd = 1'b1;
        it.data = 8'($urandom);
        q.insert(q.size(), it);
    endtask

    task automatic add_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++) add_feed(w[8*i +: 8]);
    endtask

    task automatic add_header(input logic [7:0] f);
        add_word(lfd_pkg::FRAME_MAGIC);
        add_feed(f);
        add_feed(8'($urandom));
        if (f[3]) for (int i = 0; i < 8; i++) add_feed(8'($urandom));
        if (f[0]) for (int i = 0; i < 4; i++) add_feed(8'($urandom));
        add_feed(8'($urandom));
    endtask

    task automatic blk_byte(input logic [7:0] b, ref int nbytes);
        t_cmd_item it;
        it.cmd = 1'b0;
        it.data = b;
        blk_q.insert(blk_q.size(), it);
        nbytes++;
    endtask

    // Length beyond the token nibble, as a run of 0xFF bytes and a final byte
    task automatic blk_ext_len(input int unsigned extra, ref int nbytes);
        while (extra >= 255) begin
            blk_byte(lfd_pkg::BYTE_EXT, nbytes);
            extra -= 255;
        end
        blk_byte(8'(extra), nbytes);
    endtask

    task automatic add_compressed_block();
        int          nseq, nbytes, produced_cnt, lit, m, d, dmax;
        bit          last_seq, with_match;
        logic [3:0]  lnib, mn;
        nbytes = 0;
        produced_cnt = 0;
        blk_q.delete();
        nseq = $urandom_range(1, 4);
        for (int s = 0; s < nseq; s++) begin
            last_seq = (s == nseq - 1);
            if ($urandom_range(0, 9) == 0) lit = $urandom_range(15, 300);
            else lit = $urandom_range(0, 14);
            // an empty final sequence closes a block with no output at all
            if (s == 0 && !(last_seq && $urandom_range(0, 5) == 0) && lit == 0) lit = 1;
            with_match = !last_seq || ($urandom_range(0, 2) == 0);
            if (produced_cnt + lit == 0) with_match = 1'b0;
            if ($urandom_range(0, 9) == 0) m = $urandom_range(19, 600);
            else m = $urandom_range(4, 18);
            lnib = (lit >= 15) ? 4'hF : 4'(lit);
            mn = !with_match ? 4'h0 : (m - 4 >= 15) ? 4'hF : 4'(m - 4);
            blk_byte({lnib, mn}, nbytes);
            if (lit >= 15) blk_ext_len(lit - 15, nbytes);
            for (int i = 0; i < lit; i++) blk_byte(8'($urandom), nbytes);
            produced_cnt += lit;
            if (with_match) begin
                dmax = (produced_cnt > 65535) ? 65535 : produced_cnt;
                if ($urandom_range(0, 1)) d = $urandom_range(1, (dmax < 4) ? dmax : 4);
                else d = $urandom_range(1, dmax);
                blk_byte(8'(d), nbytes);
                blk_byte(8'(d >> 8), nbytes);
                if (m - 4 >= 15) blk_ext_len(m - 19, nbytes);
                for (int i = 0; i < m; i++) begin
                    // a stray feed in the middle of a copy is answered with a misplaced status
                    if ($urandom_range(0, 39) == 0) begin
                        t_cmd_item it;
                        it.cmd = 1'b0;
                        it.data = 8'($urandom);
                        blk_q.insert(blk_q.size(), it);
                    end
                    add_drain(blk_q);
                end
                produced_cnt += m;
            end
        end
        add_word(32'(nbytes));
        foreach (blk_q[i]) cmd_q.insert(cmd_q.size(), blk_q[i]);
    endtask

    task automatic add_frame();
        logic [7:0] f;
        int         nblk, sz;
        f = 8'($urandom);
        if ($urandom_range(0, 3) == 0) add_drain(cmd_q);
        add_header(f);
        nblk = $urandom_range(1, 3);
        for (int b = 0; b < nblk; b++) begin
            if ($urandom_range(0, 2) == 0) begin
                sz = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
                add_word(32'h8000_0000 | 32'(sz));
                for (int i = 0; i < sz; i++) add_feed(8'($urandom));
            end else begin
                add_compressed_block();
            end
            if (f[4]) add_word($urandom);
        end
        add_word(32'd0);
        if (f[2]) add_word($urandom);
    endtask

    // ------------------------------------------------------------------------
    // Driver: input channel and output back-pressure
    // ------------------------------------------------------------------------
    logic      in_taken;
    int        gap_cnt   = 0;
    int        stall_cnt = 0;
    t_cmd_item cur;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            out_ch.ready <= 1'b0;
        end else begin
            if (!in_ch.valid || in_taken) begin
                if (gap_cnt > 0) begin
                    gap_cnt--;
                    in_ch.valid <= 1'b0;
                end else if (cmd_q.size() > 0) begin
                    cur = cmd_q.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.command <= cur.cmd;
                    in_ch.in_byte <= cur.data;
                    if (cmd_q.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0)
                        gap_cnt = $urandom_range(1, 11);
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
            if (stall_cnt > 0) begin
                stall_cnt--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                if (cmd_q.size() > TAIL_ITEMS && $urandom_range(0, 9) == 0)
                    stall_cnt = $urandom_range(1, 11);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on input transactions, check output transactions
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (decoded_q.size() == 0) begin
                    $error("unexpected result: out_byte %0d out_kind %0d status %0d",
                           out_ch.out_byte, out_ch.out_kind, out_ch.status);
                    fail_cnt++;
                end else begin
                    t_out_item e;
                    e = decoded_q.pop_front();
                    if (out_ch.out_byte !== e.data) begin
                        $error("out_byte: expected %0d, actual %0d", e.data, out_ch.out_byte);
                        fail_cnt++;
                    end
                    if (out_ch.out_kind !== e.kind) begin
                        $error("out_kind: expected %0d, actual %0d", e.kind, out_ch.out_kind);
                        fail_cnt++;
                    end
                    if (out_ch.last_in_block !== e.last) begin
                        $error("last_in_block: expected %0d, actual %0d", e.last,
                               out_ch.last_in_block);
                        fail_cnt++;
                    end
                    if (out_ch.status !== e.status) begin
                        $error("status: expected %0d, actual %0d", e.status, out_ch.status);
                        fail_cnt++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                decode_transaction(in_ch.command, in_ch.in_byte);
        end
        in_taken <= i_rst_n && in_ch.valid && in_ch.ready;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int err_sel;
        in_ch.valid = 1'b0;
        in_ch.command = 1'b0;
        in_ch.in_byte = 8'd0;
        out_ch.ready = 1'b0;
        in_taken = 1'b0;
        i_rst_n = 1'b0;
        restart_frame();

        // Directed: stray drain, minimal frame, empty raw block,
        // overlapping match with a stray feed inside it, end mark
        add_drain(cmd_q);
        add_header(8'h00);
        add_word(32'h8000_0000);
        add_word(32'd4);
        add_feed(8'h10);
        add_feed(8'hFF);
        add_feed(8'h01);
        add_feed(8'h00);
        add_drain(cmd_q);
        add_drain(cmd_q);
        add_feed(8'h00);
        add_drain(cmd_q);
        add_drain(cmd_q);
        add_word(32'd0);

        // Random frames
        while (cmd_q.size() < ITEM_TARGET) add_frame();

        // Finish on one lock-up condition
        err_sel = $urandom_range(0, 2);
        if (err_sel == 0) begin
            add_word(32'h184D_2205);
        end else begin
            add_header(8'h00);
            if (err_sel == 1) begin
                add_word(32'd4);
                add_feed(8'h10);
                add_feed(8'($urandom));
                add_feed(8'h05);
                add_feed(8'h00);
            end else begin
                add_word(32'd1);
                add_feed(8'hF0);
            end
        end
        for (int i = 0; i < 6; i++) begin
            if ($urandom_range(0, 1)) add_drain(cmd_q);
            else add_feed(8'($urandom));
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_q.size() > 0 || in_ch.valid) @(posedge i_clk);
        while (decoded_q.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (fail_cnt == 0 && decoded_q.size() == 0)
            $display("lz4_frame_decompressor_unit test passed");
        else
            $display("lz4_frame_decompressor_unit test failed");
        $finish;
    end

    // Timeout
    initial begin
        #2_000_000;
        $display("lz4_frame_decompressor_unit test failed");
        $finish;
    end

endmodule
